/* rtl/bkms_pkg.sv */
package bkms_pkg;

  localparam int SKETCH_SIZE      = 20;
  localparam int WORDS_PER_DIGEST = 4;

  localparam int VALUE_W = 32;
  localparam int CPS_W   = 16;
  localparam int SEG_W   = 32;
  localparam int RANK_W  = 5;

  // fill count and scan position run 0..SKETCH_SIZE, store index 0..SKETCH_SIZE-1
  localparam int POS_W  = $clog2(SKETCH_SIZE + 1);
  localparam int IDX_W  = $clog2(SKETCH_SIZE);
  localparam int WIDX_W = (WORDS_PER_DIGEST > 1) ? $clog2(WORDS_PER_DIGEST) : 1;

  localparam logic [CPS_W-1:0] CPS_RESET = 16'd16;

  typedef struct packed {
    logic [VALUE_W-1:0] digest_word_0;
    logic [VALUE_W-1:0] digest_word_1;
    logic [VALUE_W-1:0] digest_word_2;
    logic [VALUE_W-1:0] digest_word_3;
    logic               end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sketch_value;
    logic [RANK_W-1:0]  entry_position;
    logic [SEG_W-1:0]   segment_index;
    logic               last_entry;
  } out_item_t;

endpackage

/* rtl/bkms_store.sv */
module bkms_store #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bottom_k_minhash_sketch_unit.sv */
// Bottom-k min-hash sketch unit.
//
// in_*  : one chunk digest per transfer (four 32-bit words plus end_of_file).
// out_* : sketch entries, one per transfer, ranks 0..19 in ascending order,
//         last_entry set on rank 19. Unfilled entries read zero.
// cfg_* : cfg_wr_en writes chunks_per_segment (reset 16); write only while idle.
//
// Each digest word goes through one comparator over the sorted store: a scan
// down from the fill count to find the slot p, then a shift pass moving the
// larger entries up one place, from min(n, 19) down, n = fill count, then the
// write of the new value at p; a duplicate or a discarded value ends after its
// scan. All four words are followed by one close step; in_ready is low from
// the take of a digest until the sequencer is idle again.
// When the segment closes, the sketch streams out one entry per cycle while
// out_ready is high; a stall on out_ready holds the sequencer.
// The output register lets the next digest be taken while the last entry
// still waits.
// Reset (rst, synchronous) empties the store, zeroes the chunk count and the
// segment number and restores chunks_per_segment to 16.
module bottom_k_minhash_sketch_unit
  import bkms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [CPS_W-1:0] cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_SHIFT,
    ST_CLOSE,
    ST_EMIT
  } state_t;

  state_t             state;
  logic [VALUE_W-1:0] words [WORDS_PER_DIGEST];
  logic               eof;
  logic [WIDX_W-1:0]  word_idx;
  logic [VALUE_W-1:0] v;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   k;
  logic [POS_W-1:0]   filled;
  logic [CPS_W-1:0]   chunks;
  logic [CPS_W-1:0]   cps;
  logic [SEG_W-1:0]   seg;
  logic [IDX_W-1:0]   rank;

  logic [IDX_W-1:0]   raddr;
  logic [VALUE_W-1:0] rdata;
  logic               st_we;
  logic [IDX_W-1:0]   waddr;
  logic [VALUE_W-1:0] wdata;
  logic               v_eq;
  logic               v_gt;
  logic               scan_step;
  logic [POS_W-1:0]   pos_dec;
  logic [POS_W-1:0]   pos_dec2;
  logic [POS_W-1:0]   k_dec;
  logic [POS_W-1:0]   k_dec2;
  logic [POS_W-1:0]   k_first;
  logic [POS_W-1:0]   k_first_dec;
  logic [POS_W-1:0]   filled_dec;
  logic [IDX_W-1:0]   rank_inc;
  logic [CPS_W-1:0]   chunks_next;
  logic               out_free;

  assign pos_dec     = pos - 1'b1;
  assign pos_dec2    = pos - POS_W'(2);
  assign k_dec       = k - 1'b1;
  assign k_dec2      = k - POS_W'(2);
  assign k_first     = (filled < POS_W'(SKETCH_SIZE)) ? filled : POS_W'(SKETCH_SIZE - 1);
  assign k_first_dec = k_first - 1'b1;
  assign filled_dec  = filled - 1'b1;
  assign rank_inc    = rank + 1'b1;
  assign chunks_next = chunks + 1'b1;
  assign out_free    = !out_valid || out_ready;
  assign in_ready    = (state == ST_IDLE);

  // the one shared comparator
  assign v_eq = (v == rdata);
  assign v_gt = (v > rdata);

  assign scan_step = (pos != '0) && !v_eq && !v_gt;

  // registered read: the address set here is the entry seen in the next cycle
  always_comb begin
    case (state)
      ST_LOAD:  raddr = filled_dec[IDX_W-1:0];
      ST_SCAN:  raddr = scan_step ? pos_dec2[IDX_W-1:0] : k_first_dec[IDX_W-1:0];
      ST_SHIFT: raddr = k_dec2[IDX_W-1:0];
      ST_EMIT:  raddr = out_free ? rank_inc : rank;
      default:  raddr = '0;
    endcase
  end

  always_comb begin
    st_we = (state == ST_SHIFT);
    if (k > pos) begin
      waddr = k[IDX_W-1:0];
      wdata = rdata;
    end else begin
      waddr = pos[IDX_W-1:0];
      wdata = v;
    end
  end

  bkms_store #(
    .WIDTH (VALUE_W),
    .DEPTH (SKETCH_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      filled    <= '0;
      chunks    <= '0;
      cps       <= CPS_RESET;
      seg       <= '0;
      out_valid <= 1'b0;
      word_idx  <= '0;
      rank      <= '0;
    end else begin
      if (cfg_wr_en) begin
        cps <= cfg_wr_data;
      end
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            words[0] <= in_data.digest_word_0;
            words[1] <= in_data.digest_word_1;
            words[2] <= in_data.digest_word_2;
            words[3] <= in_data.digest_word_3;
            eof      <= in_data.end_of_file;
            word_idx <= '0;
            state    <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          v     <= words[word_idx];
          pos   <= filled;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (pos != '0 && v_eq) begin
            // duplicate: drop the word
            if (word_idx == WIDX_W'(WORDS_PER_DIGEST - 1)) begin
              state <= ST_CLOSE;
            end else begin
              word_idx <= word_idx + 1'b1;
              state    <= ST_LOAD;
            end
          end else if (pos == '0 || v_gt) begin
            if (pos >= POS_W'(SKETCH_SIZE)) begin
              // full and larger than every entry
              if (word_idx == WIDX_W'(WORDS_PER_DIGEST - 1)) begin
                state <= ST_CLOSE;
              end else begin
                word_idx <= word_idx + 1'b1;
                state    <= ST_LOAD;
              end
            end else begin
              k     <= k_first;
              state <= ST_SHIFT;
            end
          end else begin
            pos <= pos_dec;
          end
        end
        ST_SHIFT: begin
          if (k > pos) begin
            k <= k_dec;
          end else begin
            if (filled < POS_W'(SKETCH_SIZE)) begin
              filled <= filled + 1'b1;
            end
            if (word_idx == WIDX_W'(WORDS_PER_DIGEST - 1)) begin
              state <= ST_CLOSE;
            end else begin
              word_idx <= word_idx + 1'b1;
              state    <= ST_LOAD;
            end
          end
        end
        ST_CLOSE: begin
          chunks <= chunks_next;
          rank   <= '0;
          if (chunks_next == cps || eof) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_data.sketch_value   <= (POS_W'(rank) < filled) ? rdata : '0;
            out_data.entry_position <= RANK_W'(rank);
            out_data.segment_index  <= seg;
            out_data.last_entry     <= (rank == IDX_W'(SKETCH_SIZE - 1));
            if (rank == IDX_W'(SKETCH_SIZE - 1)) begin
              filled <= '0;
              chunks <= '0;
              seg    <= seg + 1'b1;
              state  <= ST_IDLE;
            end else begin
              rank <= rank + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= POS_W'(SKETCH_SIZE))
    else $error("fill count beyond sketch size");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (pos <= filled))
    else $error("scan position above fill count");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after a digest transfer");

  a_seg_step: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && seg != $past(seg)) |-> (out_valid && out_data.last_entry))
    else $error("segment number moved without a last entry");

endmodule
